/* design/ctc_pkg.sv */
// shared constants for the cache tag lookup block
package ctc_pkg;

  localparam int LINES_DEF    = 256;
  localparam int MAX_WAYS_DEF = 8;

  localparam int CFG_AW = 2;
  localparam int CFG_DW = 5;

  // idx is at most 15 bits wide, a line count at most 2^15
  localparam int IDX_W = 15;
  localparam int CNT_W = 16;

  localparam logic [1:0] MODE_DIRECT = 2'd0;
  localparam logic [1:0] MODE_FULLY  = 2'd1;
  localparam logic [1:0] MODE_SET    = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic [CFG_AW-1:0] REG_MODE     = 2'd0;
  localparam logic [CFG_AW-1:0] REG_OFFSET   = 2'd1;
  localparam logic [CFG_AW-1:0] REG_INDEX    = 2'd2;
  localparam logic [CFG_AW-1:0] REG_WAYS_LOG = 2'd3;

  localparam logic [1:0] MODE_RST   = 2'd0;
  localparam logic [4:0] OFFSET_RST = 5'd6;
  localparam logic [3:0] INDEX_RST  = 4'd8;
  localparam logic [1:0] WAYS_RST   = 2'd0;

endpackage

/* design/ctc_mod_unit.sv */
// remainder by a constant divisor through a reciprocal multiply, three pipeline stages
module ctc_mod_unit import ctc_pkg::*; #(
  parameter int DVW = 22,
  parameter int DIV = LINES_DEF,
  parameter int RW  = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [DVW-1:0] dividend_i,
  output logic           done_o,
  output logic [RW-1:0]  rem_o
);

  // quotient is exact for any dividend below 2^DVW with this shift and rounded-up factor
  localparam int LG = $clog2(DIV);
  localparam int SH = DVW + LG;
  localparam int MW = DVW + 2;
  localparam longint unsigned MUL_L = ((64'd1 << SH) + 64'(DIV) - 64'd1) / 64'(DIV);
  localparam logic [MW-1:0]  MUL   = MW'(MUL_L);
  localparam logic [DVW-1:0] DIV_C = DVW'(DIV);

  logic              mul_v_q, sub_v_q, done_q;
  logic [DVW-1:0]    dvd_q;
  logic [DVW-1:0]    quo_q;
  logic [RW-1:0]     rem_q;
  logic [DVW+MW-1:0] prod;
  logic [DVW-1:0]    quo_d;
  logic [DVW-1:0]    rem_d;

  always_comb begin
    prod  = (DVW+MW)'(dvd_q) * (DVW+MW)'(MUL);
    quo_d = DVW'(prod >> SH);
    rem_d = dvd_q - quo_q * DIV_C;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_v_q <= 1'b0;
      sub_v_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      mul_v_q <= start_i;
      sub_v_q <= mul_v_q;
      done_q  <= sub_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
    end
    if (mul_v_q) begin
      quo_q <= quo_d;
    end
    if (sub_v_q) begin
      rem_q <= rem_d[RW-1:0];
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

/* design/ctc_cell.sv */
// one cache line: tag, valid bit and a stage of the lookup chain
module ctc_cell import ctc_pkg::*; #(
  parameter int LINES = LINES_DEF,
  parameter int IDX   = 0,
  parameter int LW    = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             tok_v_i,
  input  logic             hit_f_i,
  input  logic [LW-1:0]    hit_r_i,
  input  logic             emp_f_i,
  input  logic [LW-1:0]    emp_r_i,
  output logic             tok_v_o,
  output logic             hit_f_o,
  output logic [LW-1:0]    hit_r_o,
  output logic             emp_f_o,
  output logic [LW-1:0]    emp_r_o,
  input  logic [31:0]      qtag_i,
  input  logic [LW-1:0]    base_i,
  input  logic [CNT_W-1:0] weff_i,
  input  logic             wr_en_i,
  input  logic [LW-1:0]    wr_line_i,
  input  logic [31:0]      wr_tag_i
);

  logic          valid_q;
  logic [31:0]   tag_q;
  logic          tok_v_q, hit_f_q, emp_f_q;
  logic [LW-1:0] hit_r_q, emp_r_q;
  logic [LW:0]   diff;
  logic [LW-1:0] rank;
  logic          cand;

  // rank of this line within the candidate set, wrapping past the top line
  always_comb begin
    diff = (LW+1)'(IDX) + (LW+1)'(LINES) - {1'b0, base_i};
    if (diff >= (LW+1)'(LINES)) begin
      diff = diff - (LW+1)'(LINES);
    end
    rank = diff[LW-1:0];
    cand = (CNT_W'(rank) < weff_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_v_q <= 1'b0;
    end else begin
      tok_v_q <= tok_v_i;
      if (wr_en_i && (wr_line_i == LW'(IDX))) begin
        valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_line_i == LW'(IDX))) begin
      tag_q <= wr_tag_i;
    end
    hit_f_q <= hit_f_i;
    hit_r_q <= hit_r_i;
    emp_f_q <= emp_f_i;
    emp_r_q <= emp_r_i;
    if (cand && valid_q && (tag_q == qtag_i) && (!hit_f_i || rank < hit_r_i)) begin
      hit_f_q <= 1'b1;
      hit_r_q <= rank;
    end
    if (cand && !valid_q && (!emp_f_i || rank < emp_r_i)) begin
      emp_f_q <= 1'b1;
      emp_r_q <= rank;
    end
  end

  assign tok_v_o = tok_v_q;
  assign hit_f_o = hit_f_q;
  assign hit_r_o = hit_r_q;
  assign emp_f_o = emp_f_q;
  assign emp_r_o = emp_r_q;

endmodule

/* design/cache_tag_hit_miss_model.sv */
// cache tag store top level: sequencer, chain of line cells, remainder units
//
//   channel   handshake            payload
//   command   start_i / busy_o     addr_i, victim_pick_i
//   result    done_o (strobe)      hit_o, line_used_o
//   config    cfg_we_i             cfg_idx_i, cfg_data_i
//
// busy_o stays high while the address is split, the base line remainder is formed, the
// lookup word walks the chain one line a cycle, the line number remainder is formed and
// done_o is shown; a miss in a full set in set mode adds the victim pick, and the unused
// mode code goes from the address split straight to done_o.
// reset clears valid bits, fifo pointer, state and config registers; tags stay undefined.
// busy_o is high from the cycle after acceptance to the done_o cycle; results cannot be held off.
module cache_tag_hit_miss_model import ctc_pkg::*; #(
  parameter int LINES    = LINES_DEF,
  parameter int MAX_WAYS = MAX_WAYS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [31:0]       addr_i,
  input  logic [7:0]        victim_pick_i,
  output logic              done_o,
  output logic              hit_o,
  output logic [7:0]        line_used_o,
  input  logic              cfg_we_i,
  input  logic [CFG_AW-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_data_i
);

  localparam int LW  = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int WW  = $clog2(MAX_WAYS + 1);
  localparam int DVW = IDX_W + WW;

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_BASE, S_WAIT, S_PICK, S_LINE, S_OUT
  } state_e;

  state_e         state_q;
  logic [1:0]     mode_q;
  logic [4:0]     offset_q;
  logic [3:0]     index_q;
  logic [1:0]     ways_q;
  logic [31:0]    addr_q;
  logic [7:0]     pick_q;
  logic [31:0]    qtag_q;
  logic [CNT_W-1:0] weff_q, n_q;
  logic [LW-1:0]  base_q, line_q, fifo_q;
  logic           hit_q, wr_q, tok_go_q;
  logic           mstart_q, wstart_q;
  logic [DVW-1:0] mdvd_q;
  logic           mdone, wdone;
  logic [LW-1:0]  mrem;
  logic [WW-1:0]  wrem;

  // combinational address split
  logic [31:0]      sh_off, tag_hi;
  logic [5:0]       sh_sum;
  logic [CNT_W-1:0] count, n_c;
  logic [IDX_W-1:0] idx;
  logic [WW-1:0]    w_c;
  logic [3:0]       wlog_c;
  logic             w_clamp;
  logic [7:0]       pick_lo;
  logic [LW-1:0]    fifo_mod, rank_sel;

  always_comb begin
    sh_off = addr_q >> offset_q;
    sh_sum = {1'b0, offset_q} + {2'b00, index_q};
    tag_hi = (sh_sum >= 6'd32) ? 32'd0 : (addr_q >> sh_sum[4:0]);
    count  = CNT_W'(1) << index_q;
    idx    = sh_off[IDX_W-1:0] & IDX_W'(count - CNT_W'(1));
    n_c    = (count > CNT_W'(LINES)) ? CNT_W'(LINES) : count;
    wlog_c = 4'd1 << ways_q;
    w_clamp = (32'(wlog_c) > 32'(MAX_WAYS));
    w_c    = w_clamp ? WW'(MAX_WAYS) : WW'(wlog_c);
    // unclamped way counts are powers of two, so the pick reduces to a mask
    pick_lo = pick_q & 8'(wlog_c - 4'd1);
    fifo_mod = (n_q == CNT_W'(LINES)) ? fifo_q : (fifo_q & LW'(n_q - CNT_W'(1)));
  end

  // chain wiring
  logic          tv   [LINES+1];
  logic          hf   [LINES+1];
  logic [LW-1:0] hr   [LINES+1];
  logic          ef   [LINES+1];
  logic [LW-1:0] er   [LINES+1];
  logic          wr_en;

  assign tv[0] = tok_go_q;
  assign hf[0] = 1'b0;
  assign hr[0] = '0;
  assign ef[0] = 1'b0;
  assign er[0] = '0;
  assign wr_en = (state_q == S_OUT) && wr_q;

  for (genvar k = 0; k < LINES; k++) begin : g_cell
    ctc_cell #(.LINES(LINES), .IDX(k), .LW(LW)) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .tok_v_i   (tv[k]),
      .hit_f_i   (hf[k]),
      .hit_r_i   (hr[k]),
      .emp_f_i   (ef[k]),
      .emp_r_i   (er[k]),
      .tok_v_o   (tv[k+1]),
      .hit_f_o   (hf[k+1]),
      .hit_r_o   (hr[k+1]),
      .emp_f_o   (ef[k+1]),
      .emp_r_o   (er[k+1]),
      .qtag_i    (qtag_q),
      .base_i    (base_q),
      .weff_i    (weff_q),
      .wr_en_i   (wr_en),
      .wr_line_i (line_q),
      .wr_tag_i  (qtag_q)
    );
  end

  ctc_mod_unit #(.DVW(DVW), .DIV(LINES), .RW(LW)) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mstart_q),
    .dividend_i (mdvd_q),
    .done_o     (mdone),
    .rem_o      (mrem)
  );

  ctc_mod_unit #(.DVW(8), .DIV(MAX_WAYS), .RW(WW)) u_way (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (wstart_q),
    .dividend_i (pick_q),
    .done_o     (wdone),
    .rem_o      (wrem)
  );

  assign rank_sel = hf[LINES] ? hr[LINES] : er[LINES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      mode_q   <= MODE_RST;
      offset_q <= OFFSET_RST;
      index_q  <= INDEX_RST;
      ways_q   <= WAYS_RST;
      fifo_q   <= '0;
      mstart_q <= 1'b0;
      wstart_q <= 1'b0;
      tok_go_q <= 1'b0;
    end else begin
      mstart_q <= 1'b0;
      wstart_q <= 1'b0;
      tok_go_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MODE:     mode_q   <= cfg_data_i[1:0];
          REG_OFFSET:   offset_q <= cfg_data_i[4:0];
          REG_INDEX:    index_q  <= cfg_data_i[3:0];
          REG_WAYS_LOG: ways_q   <= cfg_data_i[1:0];
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            addr_q  <= addr_i;
            pick_q  <= victim_pick_i;
            state_q <= S_PREP;
          end
        end
        S_PREP: begin
          hit_q  <= 1'b0;
          wr_q   <= 1'b0;
          n_q    <= n_c;
          case (mode_q)
            MODE_DIRECT: begin
              qtag_q   <= tag_hi;
              weff_q   <= CNT_W'(1);
              mdvd_q   <= DVW'(idx);
              mstart_q <= 1'b1;
              state_q  <= S_BASE;
            end
            MODE_FULLY: begin
              qtag_q   <= sh_off;
              weff_q   <= n_c;
              mdvd_q   <= '0;
              mstart_q <= 1'b1;
              state_q  <= S_BASE;
            end
            MODE_SET: begin
              qtag_q   <= tag_hi;
              weff_q   <= CNT_W'(w_c);
              mdvd_q   <= DVW'(idx) * DVW'(w_c);
              mstart_q <= 1'b1;
              state_q  <= S_BASE;
            end
            default: begin
              // unused mode: miss on line 0, nothing written
              line_q  <= '0;
              state_q <= S_OUT;
            end
          endcase
        end
        S_BASE: begin
          if (mdone) begin
            base_q   <= mrem;
            tok_go_q <= 1'b1;
            state_q  <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (tv[LINES]) begin
            hit_q  <= hf[LINES];
            wr_q   <= !hf[LINES];
            if (hf[LINES] || ef[LINES]) begin
              mdvd_q   <= DVW'(base_q) + DVW'(rank_sel);
              mstart_q <= 1'b1;
              state_q  <= S_LINE;
            end else if (mode_q == MODE_FULLY) begin
              fifo_q   <= (CNT_W'(fifo_mod) == n_q - CNT_W'(1)) ? '0 : fifo_mod + 1'b1;
              mdvd_q   <= DVW'(base_q) + DVW'(fifo_mod);
              mstart_q <= 1'b1;
              state_q  <= S_LINE;
            end else if (mode_q == MODE_SET) begin
              wstart_q <= 1'b1;
              state_q  <= S_PICK;
            end else begin
              mdvd_q   <= DVW'(base_q);
              mstart_q <= 1'b1;
              state_q  <= S_LINE;
            end
          end
        end
        S_PICK: begin
          if (wdone) begin
            mdvd_q   <= DVW'(base_q) + (w_clamp ? DVW'(wrem) : DVW'(pick_lo));
            mstart_q <= 1'b1;
            state_q  <= S_LINE;
          end
        end
        S_LINE: begin
          if (mdone) begin
            line_q  <= mrem;
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o      = (state_q != S_IDLE);
  assign done_o      = (state_q == S_OUT);
  assign hit_o       = hit_q;
  assign line_used_o = 8'(line_q);

endmodule

/* tb/sv/cache_tag_hit_miss_model_test.sv */
// testbench for the cache tag lookup block: directed and random lookups in all modes
`timescale 1ns / 100ps

module cache_tag_hit_miss_model_test;
  import ctc_pkg::*;

  localparam int NLINES = LINES_DEF;
  localparam int NWAYS  = MAX_WAYS_DEF;

  typedef struct packed {
    logic       hit;
    logic [7:0] line;
  } lookup_res_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic [31:0]       addr_i = '0;
  logic [7:0]        victim_pick_i = '0;
  logic              cfg_we_i = 1'b0;
  logic [CFG_AW-1:0] cfg_idx_i = '0;
  logic [CFG_DW-1:0] cfg_data_i = '0;
  logic              busy_o;
  logic              done_o;
  logic              hit_o;
  logic [7:0]        line_used_o;

  cache_tag_hit_miss_model DUT (
    .clk_i, .rst_ni, .start_i, .busy_o, .addr_i, .victim_pick_i,
    .done_o, .hit_o, .line_used_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always #1 clk_i = ~clk_i;

  // predictor state
  logic [1:0]  cur_mode = MODE_RST;
  logic [4:0]  cur_off  = OFFSET_RST;
  logic [3:0]  cur_idx  = INDEX_RST;
  logic [1:0]  cur_ways = WAYS_RST;
  logic [31:0] tag_mem [NLINES];
  bit          valid_mem [NLINES];
  longint unsigned fifo_ptr = 0;

  lookup_res_t pending_q [$];
  logic [31:0] addr_pool [$];
  int          errors = 0;
  int          burst_left = 0;

  function automatic logic [31:0] shr32(input logic [31:0] v, input int s);
    return (s >= 32) ? 32'd0 : (v >> s);
  endfunction

  task automatic lookup(input logic [31:0] a, input logic [7:0] pick,
                        output lookup_res_t res);
    longint unsigned cnt, idx, n, w, l, line, empty;
    logic [31:0] tag_hi, tag;
    bit have_empty, hit;
    cnt = 64'd1 << cur_idx;
    idx = shr32(a, cur_off) & (cnt - 1);
    tag_hi = shr32(a, cur_off + cur_idx);
    hit = 0;
    line = 0;
    have_empty = 0;
    empty = 0;
    case (cur_mode)
      MODE_DIRECT: begin
        line = idx % NLINES;
        if (valid_mem[line] && tag_mem[line] == tag_hi) hit = 1;
        else begin
          tag_mem[line] = tag_hi;
          valid_mem[line] = 1;
        end
      end
      MODE_FULLY: begin
        tag = shr32(a, cur_off);
        n = (cnt > NLINES) ? NLINES : cnt;
        for (longint unsigned i = 0; i < n && !hit; i++) begin
          if (valid_mem[i]) begin
            if (tag_mem[i] == tag) begin
              hit = 1;
              line = i;
            end
          end else if (!have_empty) begin
            have_empty = 1;
            empty = i;
          end
        end
        if (!hit) begin
          if (have_empty) line = empty;
          else begin
            line = fifo_ptr % n;
            fifo_ptr = (line + 1) % n;
          end
          tag_mem[line] = tag;
          valid_mem[line] = 1;
        end
      end
      MODE_SET: begin
        w = 64'd1 << cur_ways;
        if (w > NWAYS) w = NWAYS;
        for (longint unsigned i = 0; i < w && !hit; i++) begin
          l = (idx * w + i) % NLINES;
          if (valid_mem[l]) begin
            if (tag_mem[l] == tag_hi) begin
              hit = 1;
              line = l;
            end
          end else if (!have_empty) begin
            have_empty = 1;
            empty = i;
          end
        end
        if (!hit) begin
          line = (idx * w + (have_empty ? empty : (pick % w))) % NLINES;
          tag_mem[line] = tag_hi;
          valid_mem[line] = 1;
        end
      end
      default: ;
    endcase
    res.hit = hit;
    res.line = line[7:0];
  endtask

  // result checker: the receiver takes every word on the strobe
  always @(posedge clk_i) begin
    lookup_res_t want;
    if (rst_ni && done_o) begin
      if (pending_q.size() == 0) begin
        $display("%0t: result with nothing expected, got hit %0d line %0d",
                 $realtime, hit_o, line_used_o);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (hit_o !== want.hit) begin
          $display("%0t: hit mismatch, expected %0d actual %0d",
                   $realtime, want.hit, hit_o);
          errors++;
        end
        if (line_used_o !== want.line) begin
          $display("%0t: line_used mismatch, expected %0d actual %0d",
                   $realtime, want.line, line_used_o);
          errors++;
        end
      end
    end
  end

  task automatic send_lookup(input logic [31:0] a, input logic [7:0] pick);
    lookup_res_t res;
    if (burst_left == 0) begin
      repeat ($urandom_range(0, 12)) @(posedge clk_i);
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    @(posedge clk_i);
    start_i <= 1'b1;
    addr_i <= a;
    victim_pick_i <= pick;
    do @(posedge clk_i); while (busy_o);
    start_i <= 1'b0;
    lookup(a, pick, res);
    pending_q = {pending_q, res};
    addr_pool = {addr_pool, a};
    if (addr_pool.size() > 24) void'(addr_pool.pop_front());
  endtask

  // mostly reuse recent blocks so that hits and evictions occur
  task automatic send_random;
    logic [31:0] a;
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6 && addr_pool.size() > 0) begin
      a = addr_pool[$urandom_range(0, addr_pool.size() - 1)];
      if (cur_off > 0) a = a ^ ($urandom & ((32'd1 << cur_off) - 1));
    end else if (sel < 8) begin
      a = $urandom & 32'h00FF_FFFF;
    end else begin
      a = $urandom;
    end
    send_lookup(a, 8'($urandom_range(0, 255)));
  endtask

  task automatic drain;
    while (pending_q.size() != 0) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_AW-1:0] ridx, input logic [CFG_DW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= ridx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (ridx)
      REG_MODE:     cur_mode = val[1:0];
      REG_OFFSET:   cur_off = val;
      REG_INDEX:    cur_idx = val[3:0];
      REG_WAYS_LOG: cur_ways = val[1:0];
      default: ;
    endcase
  endtask

  task automatic setup(input logic [1:0] m, input int o, input int ix, input int w);
    drain();
    cfg_write(REG_MODE, CFG_DW'(m));
    cfg_write(REG_OFFSET, CFG_DW'(o));
    cfg_write(REG_INDEX, CFG_DW'(ix));
    cfg_write(REG_WAYS_LOG, CFG_DW'(w));
  endtask

  task automatic run_words(input int n);
    repeat (n) send_random();
  endtask

  task automatic test_directed;
    // reset geometry
    send_lookup(32'h0, 8'h00);
    send_lookup(32'h0, 8'hFF);
    send_lookup(32'h3F, 8'h00);
    send_lookup(32'hFFFF_FFFF, 8'hFF);
    send_lookup(32'hFFFF_FFFF, 8'h00);
    send_lookup(32'h40, 8'h55);
    // single line, no offset
    setup(MODE_DIRECT, 0, 0, 0);
    send_lookup(32'h1, 8'h00);
    send_lookup(32'h1, 8'h00);
    send_lookup(32'h2, 8'h00);
    setup(MODE_FULLY, 24, 8, 0);
    send_lookup(32'hFF00_0000, 8'h00);
    send_lookup(32'hFFFF_FFFF, 8'h00);
    setup(MODE_SET, 6, 3, 3);
    send_lookup(32'h0000_0040, 8'hFF);
    send_lookup(32'h1000_0040, 8'h00);
    send_lookup(32'h0000_0040, 8'h00);
    // unused mode code answers a miss on line 0
    setup(MODE_UNUSED, 6, 8, 0);
    send_lookup(32'h1234_5678, 8'h12);
    send_lookup(32'h1234_5678, 8'h12);
    // geometry wider than the store wraps in set mode and is clamped in fully associative mode
    setup(MODE_SET, 0, 8, 3);
    send_lookup(32'h0000_00FF, 8'h07);
    send_lookup(32'h0001_00FF, 8'h07);
    setup(MODE_FULLY, 0, 15, 0);
    send_lookup(32'hABCD_0001, 8'h00);
    send_lookup(32'hABCD_0001, 8'h00);
  endtask

  task automatic test_direct_mapped;
    setup(MODE_DIRECT, 0, 8, 0);
    run_words(100);
    setup(MODE_DIRECT, 24, 8, 0);
    run_words(100);
    repeat (2) begin
      setup(MODE_DIRECT, $urandom_range(0, 24), $urandom_range(0, 8), $urandom_range(0, 3));
      run_words(100);
    end
  endtask

  task automatic test_fully_assoc;
    // mostly small line counts so the fifo pointer wraps often
    setup(MODE_FULLY, 4, 0, 0);
    run_words(100);
    repeat (3) begin
      setup(MODE_FULLY, $urandom_range(0, 24), $urandom_range(1, 4), 0);
      run_words(100);
    end
    setup(MODE_FULLY, 6, 8, 0);
    run_words(100);
  endtask

  task automatic test_set_assoc;
    for (int w = 0; w < 4; w++) begin
      setup(MODE_SET, $urandom_range(0, 24), $urandom_range(0, 8 - 2 * w / 2), w);
      run_words(100);
    end
    setup(MODE_SET, 24, 0, 3);
    run_words(100);
    setup(MODE_SET, 0, 8, 3);
    run_words(100);
  endtask

  task automatic test_odd_geometry;
    setup(MODE_DIRECT, $urandom_range(0, 24), $urandom_range(9, 15), 0);
    run_words(75);
    setup(MODE_SET, $urandom_range(0, 24), $urandom_range(9, 15), $urandom_range(0, 3));
    run_words(75);
    setup(MODE_UNUSED, 0, 0, 3);
    run_words(10);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_directed();
    test_direct_mapped();
    test_fully_assoc();
    test_set_assoc();
    test_odd_geometry();
    drain();
    repeat (400) @(posedge clk_i);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("cache_tag_hit_miss_model_test: PASS");
    end else begin
      $display("cache_tag_hit_miss_model_test: FAIL");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("cache_tag_hit_miss_model_test: FAIL");
    $finish;
  end

endmodule
